### rtl/ipd_pkg.sv
`default_nettype none

package ipd_pkg;

   localparam int DUR_WIDTH    = 16;
   localparam int CODE_NIBBLES = 16;
   localparam int CODE_BITS    = 4 * CODE_NIBBLES;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_END   = 2'd1,
      KIND_DATA  = 2'd2
   } line_kind_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_MARK  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_SPACE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_MARK     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_SPACE    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_SPACE   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE    = 3'd5;

   typedef struct packed {
      logic [DUR_WIDTH-1:0] header_mark_time;
      logic [DUR_WIDTH-1:0] header_space_time;
      logic [DUR_WIDTH-1:0] bit_mark_time;
      logic [DUR_WIDTH-1:0] one_space_time;
      logic [DUR_WIDTH-1:0] zero_space_time;
      logic [DUR_WIDTH-1:0] window_tolerance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      header_mark_time:  16'd3000,
      header_space_time: 16'd1700,
      bit_mark_time:     16'd550,
      one_space_time:    16'd1000,
      zero_space_time:   16'd350,
      window_tolerance:  16'd150
   };

   typedef struct packed {
      logic [DUR_WIDTH-1:0] mark_a;
      logic [DUR_WIDTH-1:0] space_a;
      logic [DUR_WIDTH-1:0] mark_b;
      logic [DUR_WIDTH-1:0] space_b;
      logic [DUR_WIDTH-1:0] mark_c;
      logic [DUR_WIDTH-1:0] space_c;
      logic [DUR_WIDTH-1:0] mark_d;
      logic [DUR_WIDTH-1:0] space_d;
   } req_item_type;

   typedef struct packed {
      line_kind_type line_kind;
      logic [3:0]    nibble_msb;
      logic [3:0]    nibble_lsb;
      logic [3:0]    invalid_mask;
      logic [7:0]    nibble_total;
      logic [63:0]   code_word;
   } rsp_item_type;

   // Decoded line handed from the classifier to the code accumulator.
   typedef struct packed {
      line_kind_type kind;
      logic [3:0]    msb;
      logic [3:0]    lsb;
      logic [3:0]    bad;
   } dec_type;

   // Strict window n - t < x < n + t, done in 17 bits so nothing wraps.
   function automatic logic in_window(input logic [DUR_WIDTH-1:0] x,
                                      input logic [DUR_WIDTH-1:0] n,
                                      input logic [DUR_WIDTH-1:0] t);
      logic [DUR_WIDTH:0] x_plus_t;
      logic [DUR_WIDTH:0] n_plus_t;
      x_plus_t = {1'b0, x} + {1'b0, t};
      n_plus_t = {1'b0, n} + {1'b0, t};
      return (x_plus_t > {1'b0, n}) && ({1'b0, x} < n_plus_t);
   endfunction

endpackage

`default_nettype wire

### rtl/ipd_req_if.sv
`default_nettype none

interface ipd_req_if import ipd_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/ipd_rsp_if.sv
`default_nettype none

interface ipd_rsp_if import ipd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/ir_pulse_distance_decoder.sv
// A request passes through the input register, then the result register.
// Throughput: one request per cycle when not stalled, set by those two registers.
// The result register stalls only while the response side holds ready low.
// Reset (synchronous, active high) restores the default timing registers and
// clears the stored code, the nibble count and both valid flags.
`default_nettype none

module ir_pulse_distance_decoder import ipd_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   ipd_req_if.sink                    req_bus,
   ipd_rsp_if.source                  rsp_bus,
   input  wire                        csr_write_enable,
   input  wire [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [CSR_DATA_WIDTH-1:0]   csr_write_data
);

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   dec_type      rsp_dec_ff;
   dec_type      dec;
   logic         out_free;
   logic         advance;
   logic [7:0]   nibble_total;
   logic [63:0]  code_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEADER_MARK:  cfg_ff.header_mark_time  <= csr_write_data;
            CSR_HEADER_SPACE: cfg_ff.header_space_time <= csr_write_data;
            CSR_BIT_MARK:     cfg_ff.bit_mark_time     <= csr_write_data;
            CSR_ONE_SPACE:    cfg_ff.one_space_time    <= csr_write_data;
            CSR_ZERO_SPACE:   cfg_ff.zero_space_time   <= csr_write_data;
            CSR_TOLERANCE:    cfg_ff.window_tolerance  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff <= req_bus.payload;
      end
   end

   ipd_line_decode u_decode (
      .cfg  (cfg_ff),
      .item (in_item_ff),
      .dec  (dec)
   );

   ipd_code_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .dec          (dec),
      .nibble_total (nibble_total),
      .code_word    (code_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_dec_ff <= dec;
      end
   end

   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.payload.line_kind    = rsp_dec_ff.kind;
   assign rsp_bus.payload.nibble_msb   = rsp_dec_ff.msb;
   assign rsp_bus.payload.nibble_lsb   = rsp_dec_ff.lsb;
   assign rsp_bus.payload.invalid_mask = rsp_dec_ff.bad;
   assign rsp_bus.payload.nibble_total = nibble_total;
   assign rsp_bus.payload.code_word    = code_word;

endmodule

`default_nettype wire

### rtl/ipd_line_decode.sv
`default_nettype none

module ipd_line_decode import ipd_pkg::*; (
   input  wire cfg_type      cfg,
   input  wire req_item_type item,
   output dec_type           dec
);

   logic [DUR_WIDTH-1:0] marks  [4];
   logic [DUR_WIDTH-1:0] spaces [4];
   logic [3:0] msb;
   logic [3:0] lsb;
   logic [3:0] bad;
   logic       is_header;
   logic       is_end;

   assign marks[0]  = item.mark_a;
   assign marks[1]  = item.mark_b;
   assign marks[2]  = item.mark_c;
   assign marks[3]  = item.mark_d;
   assign spaces[0] = item.space_a;
   assign spaces[1] = item.space_b;
   assign spaces[2] = item.space_c;
   assign spaces[3] = item.space_d;

   assign is_header = in_window(item.mark_a, cfg.header_mark_time, cfg.window_tolerance) &&
                      in_window(item.space_a, cfg.header_space_time, cfg.window_tolerance);
   assign is_end    = in_window(item.mark_a, cfg.bit_mark_time, cfg.window_tolerance) &&
                      (item.space_a == '0);

   // Pair a lands in bit 3 of the MSB-first forms and bit 0 of the LSB-first one.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic mark_ok;
         logic one;
         logic zero;
         mark_ok = in_window(marks[i], cfg.bit_mark_time, cfg.window_tolerance);
         one     = in_window(spaces[i], cfg.one_space_time, cfg.window_tolerance);
         zero    = !one && in_window(spaces[i], cfg.zero_space_time, cfg.window_tolerance);
         msb[3-i] = mark_ok && one;
         lsb[i]   = mark_ok && one;
         bad[3-i] = !(mark_ok && (one || zero));
      end
   end

   always_comb begin
      dec = '0;
      if (is_header) begin
         dec.kind = KIND_START;
      end else if (is_end) begin
         dec.kind = KIND_END;
      end else begin
         dec.kind = KIND_DATA;
         dec.msb  = msb;
         dec.lsb  = lsb;
         dec.bad  = bad;
      end
   end

endmodule

`default_nettype wire

### rtl/ipd_code_accum.sv
`default_nettype none

module ipd_code_accum import ipd_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          load,
   input  wire dec_type dec,
   output logic [7:0]   nibble_total,
   output logic [63:0]  code_word
);

   logic [CODE_BITS-1:0] code_ff;
   logic [CODE_BITS-1:0] code_in;
   logic [7:0]           count_ff;
   logic [7:0]           count_in;

   always_comb begin
      code_in  = code_ff;
      count_in = count_ff;
      case (dec.kind)
         KIND_START: begin
            code_in  = '0;
            count_in = '0;
         end
         KIND_DATA: begin
            // Oldest nibble falls off the top once the register is full.
            code_in = CODE_BITS'((code_ff << 4) | CODE_BITS'(dec.msb));
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= '0;
         count_ff <= '0;
      end else if (load) begin
         code_ff  <= code_in;
         count_ff <= count_in;
      end
   end

   // The state only moves when a new result is loaded, so it doubles as that result.
   assign nibble_total = count_ff;
   assign code_word    = 64'(code_ff);

endmodule

`default_nettype wire

### dv/ir_pulse_distance_decoder_test.sv
`timescale 1ns / 1ps

module ir_pulse_distance_decoder_test;
   import ipd_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;
   localparam int LONG_HOLD_CYCLES = 80;

   // Tracks the timing registers, the code register and the nibble count, and
   // holds the results still owed by the decoder in arrival order.
   class ir_frame_tracker;
      cfg_type      timing;
      logic [63:0]  code_acc;
      logic [7:0]   nibble_cnt;
      rsp_item_type awaited[$];
      int           mismatches;

      function new();
         timing = cfg_type'{16'd3000, 16'd1700, 16'd550, 16'd1000, 16'd350, 16'd150};
         code_acc = '0;
         nibble_cnt = '0;
         mismatches = 0;
      endfunction

      function void set_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_HEADER_MARK:  timing.header_mark_time = value;
            CSR_HEADER_SPACE: timing.header_space_time = value;
            CSR_BIT_MARK:     timing.bit_mark_time = value;
            CSR_ONE_SPACE:    timing.one_space_time = value;
            CSR_ZERO_SPACE:   timing.zero_space_time = value;
            CSR_TOLERANCE:    timing.window_tolerance = value;
            default: ;
         endcase
      endfunction

      // Strict window, compared as plain integers so the bounds never wrap.
      function bit in_win(input logic [15:0] v, input logic [15:0] nom);
         int x, n, t;
         x = v;
         n = nom;
         t = timing.window_tolerance;
         return (x > n - t) && (x < n + t);
      endfunction

      function void take_line(input req_item_type line);
         logic [15:0]  d [8];
         rsp_item_type want;
         bit           mark_ok, one, zero;
         for (int i = 0; i < 8; i++)
            d[i] = line[(7 - i) * 16 +: 16];
         want = '0;
         if (in_win(d[0], timing.header_mark_time) && in_win(d[1], timing.header_space_time)) begin
            want.line_kind = KIND_START;
            code_acc = '0;
            nibble_cnt = '0;
         end else if (in_win(d[0], timing.bit_mark_time) && d[1] == 16'd0) begin
            want.line_kind = KIND_END;
         end else begin
            want.line_kind = KIND_DATA;
            for (int i = 0; i < 4; i++) begin
               mark_ok = in_win(d[2 * i], timing.bit_mark_time);
               one = in_win(d[2 * i + 1], timing.one_space_time);
               zero = !one && in_win(d[2 * i + 1], timing.zero_space_time);
               want.nibble_msb[3 - i] = mark_ok && one;
               want.nibble_lsb[i] = mark_ok && one;
               want.invalid_mask[3 - i] = !(mark_ok && (one || zero));
            end
            code_acc = ((code_acc << 4) | 64'(want.nibble_msb))
                       & ({64{1'b1}} >> (64 - CODE_BITS));
            if (nibble_cnt != 8'd255)
               nibble_cnt = nibble_cnt + 8'd1;
         end
         want.nibble_total = nibble_cnt;
         want.code_word = code_acc;
         awaited.push_back(want);
      endfunction

      function void check_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void match_result(input rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result with no request outstanding: expected none, actual %0h",
                     $time, got);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         check_field("line_kind", 64'(want.line_kind), 64'(got.line_kind));
         check_field("nibble_msb", 64'(want.nibble_msb), 64'(got.nibble_msb));
         check_field("nibble_lsb", 64'(want.nibble_lsb), 64'(got.nibble_lsb));
         check_field("invalid_mask", 64'(want.invalid_mask), 64'(got.invalid_mask));
         check_field("nibble_total", 64'(want.nibble_total), 64'(got.nibble_total));
         check_field("code_word", want.code_word, got.code_word);
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   ipd_req_if req_if ();
   ipd_rsp_if rsp_if ();

   ir_frame_tracker tracker = new();

   int lines_sent = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   bit long_hold_pending = 1'b0;

   ir_pulse_distance_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic req_item_type line8(input logic [15:0] ma, sa, mb, sb, mc, sc, md, sd);
      return {ma, sa, mb, sb, mc, sc, md, sd};
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   // A duration strictly inside the window around nom, or noise if the window is empty.
   function automatic logic [15:0] near(input logic [15:0] nom);
      int lo, hi, t;
      t = tracker.timing.window_tolerance;
      lo = int'(nom) - t + 1;
      hi = int'(nom) + t - 1;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      if (lo > hi)
         return rand16();
      return 16'($urandom_range(hi, lo));
   endfunction

   function automatic req_item_type make_header();
      return line8(near(tracker.timing.header_mark_time), near(tracker.timing.header_space_time),
                   rand16(), rand16(), rand16(), rand16(), rand16(), rand16());
   endfunction

   function automatic req_item_type make_end();
      return line8(near(tracker.timing.bit_mark_time), 16'd0,
                   rand16(), rand16(), rand16(), rand16(), rand16(), rand16());
   endfunction

   // Well-formed data line for the given bits; about one pair in spoil_odds is
   // replaced by noise on its mark or its space.
   function automatic req_item_type make_data(input logic [3:0] bits, input int spoil_odds);
      req_item_type r;
      logic [15:0]  m, s;
      for (int i = 0; i < 4; i++) begin
         m = near(tracker.timing.bit_mark_time);
         s = bits[3 - i] ? near(tracker.timing.one_space_time)
                         : near(tracker.timing.zero_space_time);
         if (spoil_odds != 0 && $urandom_range(1, spoil_odds) == 1) begin
            if ($urandom_range(0, 1) == 1) m = rand16();
            else s = rand16();
         end
         r[(7 - 2 * i) * 16 +: 16] = m;
         r[(6 - 2 * i) * 16 +: 16] = s;
      end
      return r;
   endfunction

   task automatic send_line(input req_item_type item);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      tracker.take_line(item);
      lines_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                          input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      tracker.set_reg(idx, value);
   endtask

   task automatic program_regs(input cfg_type c);
      put_reg(CSR_HEADER_MARK, c.header_mark_time);
      put_reg(CSR_SPARE_LO, rand16());
      put_reg(CSR_HEADER_SPACE, c.header_space_time);
      put_reg(CSR_BIT_MARK, c.bit_mark_time);
      put_reg(CSR_ONE_SPACE, c.one_space_time);
      put_reg(CSR_ZERO_SPACE, c.zero_space_time);
      put_reg(CSR_TOLERANCE, c.window_tolerance);
      put_reg(CSR_SPARE_HI, rand16());
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // A broken frame loses either its header or its end line.
   task automatic send_frame(input int data_lines, input bit broken);
      int drop;
      drop = broken ? $urandom_range(1, 2) : 0;
      if (drop != 1) send_line(make_header());
      repeat (data_lines) send_line(make_data(4'($urandom), 8));
      if (drop != 2) send_line(make_end());
   endtask

   task automatic run_traffic(input int quota);
      int first, pick;
      first = lines_sent;
      while (lines_sent - first < quota) begin
         pick = $urandom_range(0, 9);
         sender_calm = ($urandom_range(0, 4) == 0);
         if (pick < 7)
            send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(17, 24)
                                                   : $urandom_range(0, 16), pick == 6);
         else if (pick < 9)
            send_line({$urandom, $urandom, $urandom, $urandom});
         else if ($urandom_range(0, 1) == 1)
            send_line(make_end());
         else
            send_line(make_data(4'($urandom), 0));
      end
   endtask

   // Result side: random stalls, calm stretches, and one long hold on request.
   initial begin
      int taken;
      int stall;
      taken = 0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         if (taken % 40 == 0)
            receiver_calm = ($urandom_range(0, 3) == 0);
         stall = receiver_calm ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         tracker.match_result(rsp_if.payload);
         taken++;
      end
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset timing: data before any header, window edges on both sides,
      // a one space behind a bad mark, spaces between windows, field extremes.
      send_line(line8(550, 1000, 550, 350, 550, 1000, 550, 350));
      send_line(line8(3000, 1700, 0, 0, 0, 0, 0, 0));
      send_line(line8(2851, 1849, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_line(line8(2850, 1700, 550, 1000, 550, 1000, 550, 1000));
      send_line(line8(3149, 1850, 550, 350, 550, 1000, 550, 350));
      send_line(line8(550, 1000, 401, 851, 699, 1149, 550, 1000));
      send_line(line8(550, 350, 401, 201, 699, 499, 550, 499));
      send_line(line8(400, 1000, 700, 1000, 550, 1000, 550, 350));
      send_line(line8(550, 600, 550, 500, 550, 850, 550, 1150));
      send_line(line8(550, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_line(line8(550, 1000, 550, 350, 550, 350, 550, 1000));
      send_line(line8(401, 0, 0, 0, 0, 0, 0, 0));
      send_line(line8(400, 0, 550, 1000, 550, 1000, 550, 1000));
      send_line(line8(0, 0, 0, 0, 0, 0, 0, 0));
      send_line(line8(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_line(line8(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                      16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
      send_line(line8(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                      16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
      send_line(line8(3000, 1700, 550, 1000, 550, 1000, 550, 1000));
      send_line(line8(699, 0, 550, 350, 550, 350, 550, 350));

      run_traffic(120);
      // Results back up while the sender keeps offering, then the sender
      // stops until everything is back.
      long_hold_pending = 1'b1;
      sender_calm = 1'b1;
      send_frame(20, 1'b0);
      wait_drained();
      run_traffic(110);
      wait_drained();

      // Longer timing; one frame long enough to saturate the nibble count.
      program_regs(cfg_type'{16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'd200});
      sender_calm = 1'b0;
      send_line(make_header());
      repeat (270) send_line(make_data(4'($urandom), 16));
      send_line(make_end());
      run_traffic(80);
      wait_drained();

      // Header window holds the end line, and the one and zero windows overlap.
      program_regs(cfg_type'{16'd550, 16'd40, 16'd550, 16'd400, 16'd450, 16'd150});
      send_line(line8(550, 0, 550, 420, 550, 460, 550, 300));
      send_line(line8(550, 420, 550, 460, 550, 560, 550, 300));
      run_traffic(120);
      wait_drained();

      program_regs(cfg_type'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
      run_traffic(50);
      wait_drained();

      program_regs(cfg_type'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
      run_traffic(50);
      wait_drained();

      program_regs(cfg_type'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd150});
      run_traffic(80);
      wait_drained();

      repeat (3) begin
         program_regs(cfg_type'{16'($urandom_range(2000, 12000)), 16'($urandom_range(1000, 6000)),
                                16'($urandom_range(200, 800)), 16'($urandom_range(900, 2500)),
                                16'($urandom_range(200, 900)), 16'($urandom_range(1, 400))});
         run_traffic(100);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
